// ===== rtl/procedural_texture_pixel_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the procedural texture pixel block
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef PROCEDURAL_TEXTURE_PIXEL_TOP_MACROS_SVH
`define PROCEDURAL_TEXTURE_PIXEL_TOP_MACROS_SVH

// overlapping implication
`define PTEX_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error(msg);

// non-overlapping implication
`define PTEX_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error(msg);

`endif

// ===== rtl/ptex_pkg.sv =====
// ---------------------------------------------------------------------------
// ptex_pkg
// Shared widths, register map, mode codes and colour constants.
// ---------------------------------------------------------------------------
`default_nettype none

package ptex_pkg;

  // field widths
  localparam int PIX_W     = 10;
  localparam int CLR_W     = 8;
  localparam int DIM_REG_W = 11;
  localparam int MODE_W    = 2;

  // register port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam int MAX_DIM_DEF = 1024;

  // checker divider: two quotient bits per pipeline stage
  localparam int STEP_BITS = 2;
  localparam int CHK_STG   = PIX_W / STEP_BITS;

  typedef enum logic [MODE_W-1:0] {
    MODE_CHECKER = 2'd0,
    MODE_RECT    = 2'd1,
    MODE_ELLIPSE = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_WIDTH  = 3'd1,
    REG_HEIGHT = 3'd2,
    REG_STEPS  = 3'd3,
    REG_RED    = 3'd4,
    REG_GREEN  = 3'd5,
    REG_BLUE   = 3'd6,
    REG_ALPHA  = 3'd7
  } reg_idx_t;

  // reset values
  localparam logic [MODE_W-1:0]    RST_MODE  = MODE_W'(0);
  localparam logic [DIM_REG_W-1:0] RST_DIM   = DIM_REG_W'(64);
  localparam logic [DIM_REG_W-1:0] RST_STEPS = DIM_REG_W'(8);
  localparam logic [CLR_W-1:0]     RST_FILL  = CLR_W'(255);

  // checkerboard colours
  localparam logic [CLR_W-1:0] CLR_ZERO     = CLR_W'(0);
  localparam logic [CLR_W-1:0] CLR_FULL     = CLR_W'(255);
  localparam logic [CLR_W-1:0] CLR_HALF     = CLR_W'(128);

  // mode and fill colour, handed from the register file to the datapath
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CLR_W-1:0]  red;
    logic [CLR_W-1:0]  green;
    logic [CLR_W-1:0]  blue;
    logic [CLR_W-1:0]  alpha;
  } fill_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/ptex_cfg.sv =====
// ---------------------------------------------------------------------------
// ptex_cfg
// Register file, cell size divider and ellipse radius products.
// ---------------------------------------------------------------------------
`default_nettype none
`include "procedural_texture_pixel_top_macros.svh"

module ptex_cfg import ptex_pkg::*; #(
  parameter  int MAX_DIM = MAX_DIM_DEF,
  localparam int SW      = $clog2(MAX_DIM + 1),
  localparam int RXW     = SW - 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output fill_cfg_t              fill_cfg,
  output logic      [SW-1:0]     cell_w,
  output logic      [SW-1:0]     cell_h,
  output logic      [RXW-1:0]    rad_x,
  output logic      [RXW-1:0]    rad_y,
  output logic      [2*RXW-1:0]  rad_x2,
  output logic      [2*RXW-1:0]  rad_y2,
  output logic      [4*RXW-1:0]  rad_prod,
  output logic                   ell_en,
  output logic                   calc_busy
);

  localparam int CMP_W = (SW > DIM_REG_W) ? SW : DIM_REG_W;
  localparam int CNTW  = $clog2(SW);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CALC = 2'b10
  } state_t;

  logic [MODE_W-1:0]    mode_r;
  logic [DIM_REG_W-1:0] width_r, height_r, steps_r;
  logic [CLR_W-1:0]     red_r, green_r, blue_r, alpha_r;

  state_t               state_r;
  logic [CNTW-1:0]      cnt_r;
  logic [DIM_REG_W-1:0] remw_r, remh_r;
  logic [SW-1:0]        qw_r, qh_r;
  logic [SW-1:0]        cell_w_r, cell_h_r;
  logic [2*RXW-1:0]     rad_x2_r, rad_y2_r;
  logic [4*RXW-1:0]     rad_prod_r;

  logic                 wr;
  reg_idx_t             idx;
  logic [CMP_W-1:0]     w_ext, h_ext;
  logic [SW-1:0]        w_sat, h_sat;
  logic [DIM_REG_W-1:0] steps_eff;
  logic [CNTW-1:0]      bit_idx;
  logic [DIM_REG_W:0]   stw, sth;
  logic [SW-1:0]        qw_fin, qh_fin;

  // one restoring division step: returns {quotient bit, new remainder}
  function automatic logic [DIM_REG_W:0] div_step(input logic [DIM_REG_W-1:0] rem,
                                                  input logic                 b,
                                                  input logic [DIM_REG_W-1:0] d);
    logic [DIM_REG_W:0] t;
    logic [DIM_REG_W:0] dd;
    logic [DIM_REG_W:0] diff;
    t  = {rem, b};
    dd = {1'b0, d};
    diff = t - dd;
    if (t >= dd) begin
      div_step = {1'b1, diff[DIM_REG_W-1:0]};
    end else begin
      div_step = {1'b0, t[DIM_REG_W-1:0]};
    end
  endfunction

  assign wr  = psel && penable && pwrite;
  assign idx = reg_idx_t'(paddr[CFG_AW-1:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= RST_MODE;
      width_r  <= RST_DIM;
      height_r <= RST_DIM;
      steps_r  <= RST_STEPS;
      red_r    <= RST_FILL;
      green_r  <= RST_FILL;
      blue_r   <= RST_FILL;
      alpha_r  <= RST_FILL;
    end else if (wr) begin
      case (idx)
        REG_MODE:   mode_r   <= pwdata[MODE_W-1:0];
        REG_WIDTH:  width_r  <= pwdata[DIM_REG_W-1:0];
        REG_HEIGHT: height_r <= pwdata[DIM_REG_W-1:0];
        REG_STEPS:  steps_r  <= pwdata[DIM_REG_W-1:0];
        REG_RED:    red_r    <= pwdata[CLR_W-1:0];
        REG_GREEN:  green_r  <= pwdata[CLR_W-1:0];
        REG_BLUE:   blue_r   <= pwdata[CLR_W-1:0];
        REG_ALPHA:  alpha_r  <= pwdata[CLR_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (idx)
      REG_MODE:   prdata = CFG_DW'(mode_r);
      REG_WIDTH:  prdata = CFG_DW'(width_r);
      REG_HEIGHT: prdata = CFG_DW'(height_r);
      REG_STEPS:  prdata = CFG_DW'(steps_r);
      REG_RED:    prdata = CFG_DW'(red_r);
      REG_GREEN:  prdata = CFG_DW'(green_r);
      REG_BLUE:   prdata = CFG_DW'(blue_r);
      REG_ALPHA:  prdata = CFG_DW'(alpha_r);
      default:    prdata = '0;
    endcase
  end

  // saturated frame size
  assign w_ext = CMP_W'(width_r);
  assign h_ext = CMP_W'(height_r);
  assign w_sat = (w_ext > CMP_W'(MAX_DIM)) ? SW'(MAX_DIM) : SW'(w_ext);
  assign h_sat = (h_ext > CMP_W'(MAX_DIM)) ? SW'(MAX_DIM) : SW'(h_ext);

  assign steps_eff = (steps_r == '0) ? DIM_REG_W'(1) : steps_r;

  // cell size divider, one quotient bit per cycle, msb first
  assign bit_idx = CNTW'(SW - 1) - cnt_r;
  assign stw     = div_step(remw_r, w_sat[bit_idx], steps_eff);
  assign sth     = div_step(remh_r, h_sat[bit_idx], steps_eff);
  assign qw_fin  = {qw_r[SW-2:0], stw[DIM_REG_W]};
  assign qh_fin  = {qh_r[SW-2:0], sth[DIM_REG_W]};

  always_ff @(posedge clk) begin
    if (!rst_n || wr) begin
      state_r <= ST_CALC;
      cnt_r   <= '0;
      remw_r  <= '0;
      remh_r  <= '0;
      qw_r    <= '0;
      qh_r    <= '0;
    end else begin
      case (state_r)
        ST_CALC: begin
          remw_r <= stw[DIM_REG_W-1:0];
          remh_r <= sth[DIM_REG_W-1:0];
          qw_r   <= qw_fin;
          qh_r   <= qh_fin;
          cnt_r  <= cnt_r + CNTW'(1);
          if (cnt_r == CNTW'(SW - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: ;
        default: state_r <= ST_CALC;
      endcase
    end
  end

  // latch the cell size at the last step, zero forced to one
  always_ff @(posedge clk) begin
    if ((state_r == ST_CALC) && (cnt_r == CNTW'(SW - 1))) begin
      cell_w_r <= (qw_fin == '0) ? SW'(1) : qw_fin;
      cell_h_r <= (qh_fin == '0) ? SW'(1) : qh_fin;
    end
  end

  // radii and their products, settle within the divider run
  assign rad_x = w_sat[SW-1:1];
  assign rad_y = h_sat[SW-1:1];

  always_ff @(posedge clk) begin
    rad_x2_r   <= (2*RXW)'(rad_x) * (2*RXW)'(rad_x);
    rad_y2_r   <= (2*RXW)'(rad_y) * (2*RXW)'(rad_y);
    rad_prod_r <= (4*RXW)'(rad_x2_r) * (4*RXW)'(rad_y2_r);
  end

  assign ell_en    = (rad_x != '0) && (rad_y != '0);
  assign calc_busy = (state_r == ST_CALC) || wr;

  assign fill_cfg = '{mode: mode_r, red: red_r, green: green_r, blue: blue_r, alpha: alpha_r};
  assign cell_w   = cell_w_r;
  assign cell_h   = cell_h_r;
  assign rad_x2   = rad_x2_r;
  assign rad_y2   = rad_y2_r;
  assign rad_prod = rad_prod_r;

  // a completed write always restarts the divider
  `PTEX_ASSERT_NXT(a_wr_recalc, wr, state_r == ST_CALC, "write did not restart divider")
  // divisors handed to the pixel path are never zero once settled
  `PTEX_ASSERT_IMP(a_cell_nz, state_r == ST_IDLE, (cell_w_r != '0) && (cell_h_r != '0), "zero cell size")

endmodule

`default_nettype wire

// ===== rtl/ptex_chk.sv =====
// ---------------------------------------------------------------------------
// ptex_chk
// Pipelined restoring divider for the checker cell parity of x and y.
// ---------------------------------------------------------------------------
`default_nettype none

module ptex_chk import ptex_pkg::*; #(
  parameter int SW = $clog2(MAX_DIM_DEF + 1)
) (
  input  wire logic             clk,
  input  wire logic [PIX_W-1:0] px,
  input  wire logic [PIX_W-1:0] py,
  input  wire logic [SW-1:0]    cell_w,
  input  wire logic [SW-1:0]    cell_h,
  output logic                  par_eq
);

  localparam int NREG = CHK_STG - 1;

  logic [SW-1:0]    xrem_r [NREG];
  logic [SW-1:0]    yrem_r [NREG];
  logic [PIX_W-1:0] xp_r   [NREG];
  logic [PIX_W-1:0] yp_r   [NREG];
  logic             xq_last, yq_last;

  // one restoring step: returns {quotient bit, new remainder}
  function automatic logic [SW:0] div_step(input logic [SW-1:0] rem,
                                           input logic          b,
                                           input logic [SW-1:0] d);
    logic [SW:0] t;
    logic [SW:0] dd;
    logic [SW:0] diff;
    t    = {rem, b};
    dd   = {1'b0, d};
    diff = t - dd;
    if (t >= dd) begin
      div_step = {1'b1, diff[SW-1:0]};
    end else begin
      div_step = {1'b0, t[SW-1:0]};
    end
  endfunction

  // two quotient bits per stage, msb first
  for (genvar s = 0; s < CHK_STG; s++) begin : g_stg
    logic [SW-1:0]    xin, yin;
    logic [PIX_W-1:0] xpix, ypix;
    logic [SW:0]      xs1, xs2, ys1, ys2;

    if (s == 0) begin : g_first
      assign xin  = '0;
      assign yin  = '0;
      assign xpix = px;
      assign ypix = py;
    end else begin : g_rest
      assign xin  = xrem_r[s-1];
      assign yin  = yrem_r[s-1];
      assign xpix = xp_r[s-1];
      assign ypix = yp_r[s-1];
    end

    assign xs1 = div_step(xin, xpix[PIX_W-1-STEP_BITS*s], cell_w);
    assign xs2 = div_step(xs1[SW-1:0], xpix[PIX_W-2-STEP_BITS*s], cell_w);
    assign ys1 = div_step(yin, ypix[PIX_W-1-STEP_BITS*s], cell_h);
    assign ys2 = div_step(ys1[SW-1:0], ypix[PIX_W-2-STEP_BITS*s], cell_h);

    if (s < NREG) begin : g_reg
      always_ff @(posedge clk) begin
        xrem_r[s] <= xs2[SW-1:0];
        yrem_r[s] <= ys2[SW-1:0];
        xp_r[s]   <= xpix;
        yp_r[s]   <= ypix;
      end
    end else begin : g_last
      // quotient lsb of the final step is the cell parity
      assign xq_last = xs2[SW];
      assign yq_last = ys2[SW];
    end
  end

  assign par_eq = (xq_last == yq_last);

endmodule

`default_nettype wire

// ===== rtl/ptex_ell.sv =====
// ---------------------------------------------------------------------------
// ptex_ell
// Four-stage pipeline for the integer ellipse inside test.
// ---------------------------------------------------------------------------
`default_nettype none

module ptex_ell import ptex_pkg::*; #(
  parameter int RXW = $clog2(MAX_DIM_DEF + 1) - 1
) (
  input  wire logic             clk,
  input  wire logic [PIX_W-1:0] px,
  input  wire logic [PIX_W-1:0] py,
  input  wire logic [RXW-1:0]   rad_x,
  input  wire logic [RXW-1:0]   rad_y,
  input  wire logic [2*RXW-1:0] rad_x2,
  input  wire logic [2*RXW-1:0] rad_y2,
  input  wire logic [4*RXW-1:0] rad_prod,
  input  wire logic             ell_en,
  output logic                  ell_hit
);

  localparam int DXW = (PIX_W > RXW) ? PIX_W : RXW;
  localparam int TW  = 2*DXW + 2*RXW;

  logic [DXW-1:0]   xe, ye, rxe, rye;
  logic [DXW-1:0]   dx_r, dy_r;
  logic [2*DXW-1:0] dx2_r, dy2_r;
  logic [TW-1:0]    t1_r, t2_r;
  logic [TW:0]      lhs;
  logic             inside_r;

  assign xe  = DXW'(px);
  assign ye  = DXW'(py);
  assign rxe = DXW'(rad_x);
  assign rye = DXW'(rad_y);

  // stage 1: distance from centre
  always_ff @(posedge clk) begin
    dx_r <= (xe >= rxe) ? (xe - rxe) : (rxe - xe);
    dy_r <= (ye >= rye) ? (ye - rye) : (rye - ye);
  end

  // stage 2: squares
  always_ff @(posedge clk) begin
    dx2_r <= (2*DXW)'(dx_r) * (2*DXW)'(dx_r);
    dy2_r <= (2*DXW)'(dy_r) * (2*DXW)'(dy_r);
  end

  // stage 3: cross products with the radius squares
  always_ff @(posedge clk) begin
    t1_r <= TW'(dx2_r) * TW'(rad_y2);
    t2_r <= TW'(dy2_r) * TW'(rad_x2);
  end

  // stage 4: sum and compare
  assign lhs = (TW+1)'(t1_r) + (TW+1)'(t2_r);

  always_ff @(posedge clk) begin
    inside_r <= ell_en && (lhs < (TW+1)'(rad_prod));
  end

  assign ell_hit = inside_r;

endmodule

`default_nettype wire

// ===== rtl/procedural_texture_pixel_top.sv =====
// ---------------------------------------------------------------------------
// procedural_texture_pixel_top
// Procedural RGBA texture generator: checkerboard, solid fill or ellipse.
//
//   channel   handshake                    payload
//   input     start / busy                 in_pixel_x, in_pixel_y
//   result    out_valid (one-cycle strobe) out_red, out_green, out_blue, out_alpha
//   registers psel/penable/pwrite, pready  paddr, pwdata, prdata
//
// One pixel per clock while busy is low; the strobe rises once its transfer has
// passed the input register, four pipeline registers and the output register,
// with the result valid alongside it. The checker divider (five steps of two
// quotient bits, the last ahead of the output register) and the four-stage
// ellipse multiply path run alongside each other.
// After reset and after every register write busy stays high while the cell
// size divider runs.
// Reset is synchronous, active low; it restores the register defaults.
// The result side has no back-pressure, so the pipeline never stalls.
// ---------------------------------------------------------------------------
`default_nettype none
`include "procedural_texture_pixel_top_macros.svh"

module procedural_texture_pixel_top import ptex_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [PIX_W-1:0]  in_pixel_x,
  input  wire logic [PIX_W-1:0]  in_pixel_y,
  output logic                   out_valid,
  output logic      [CLR_W-1:0]  out_red,
  output logic      [CLR_W-1:0]  out_green,
  output logic      [CLR_W-1:0]  out_blue,
  output logic      [CLR_W-1:0]  out_alpha,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  localparam int SW      = $clog2(MAX_DIM + 1);
  localparam int RXW     = SW - 1;
  localparam int STG     = CHK_STG;
  localparam int ACC_LAT = STG + 1;

  fill_cfg_t        fill_cfg;
  logic [SW-1:0]    cell_w, cell_h;
  logic [RXW-1:0]   rad_x, rad_y;
  logic [2*RXW-1:0] rad_x2, rad_y2;
  logic [4*RXW-1:0] rad_prod;
  logic             ell_en, calc_busy;
  logic             accept;
  logic             par_eq, ell_hit;

  logic [PIX_W-1:0] px_r, py_r;
  logic [STG-1:0]   vld_r;
  logic             out_valid_r;
  logic [CLR_W-1:0] red_r, green_r, blue_r, alpha_r;
  logic [CLR_W-1:0] red_nxt, green_nxt, blue_nxt, alpha_nxt;

  ptex_cfg #(.MAX_DIM(MAX_DIM)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .fill_cfg  (fill_cfg),
    .cell_w    (cell_w),
    .cell_h    (cell_h),
    .rad_x     (rad_x),
    .rad_y     (rad_y),
    .rad_x2    (rad_x2),
    .rad_y2    (rad_y2),
    .rad_prod  (rad_prod),
    .ell_en    (ell_en),
    .calc_busy (calc_busy)
  );

  assign pready = 1'b1;
  assign busy   = calc_busy;
  assign accept = start && !calc_busy;

  // input register
  always_ff @(posedge clk) begin
    if (accept) begin
      px_r <= in_pixel_x;
      py_r <= in_pixel_y;
    end
  end

  // valid bits alongside the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[STG-2:0], accept};
      out_valid_r <= vld_r[STG-1];
    end
  end

  ptex_chk #(.SW(SW)) u_chk (
    .clk    (clk),
    .px     (px_r),
    .py     (py_r),
    .cell_w (cell_w),
    .cell_h (cell_h),
    .par_eq (par_eq)
  );

  ptex_ell #(.RXW(RXW)) u_ell (
    .clk      (clk),
    .px       (px_r),
    .py       (py_r),
    .rad_x    (rad_x),
    .rad_y    (rad_y),
    .rad_x2   (rad_x2),
    .rad_y2   (rad_y2),
    .rad_prod (rad_prod),
    .ell_en   (ell_en),
    .ell_hit  (ell_hit)
  );

  // colour select per mode
  always_comb begin
    red_nxt   = CLR_ZERO;
    green_nxt = CLR_ZERO;
    blue_nxt  = CLR_ZERO;
    alpha_nxt = CLR_ZERO;
    case (fill_cfg.mode)
      MODE_CHECKER: begin
        blue_nxt  = par_eq ? CLR_FULL : CLR_ZERO;
        alpha_nxt = par_eq ? CLR_FULL : CLR_HALF;
      end
      MODE_RECT: begin
        red_nxt   = fill_cfg.red;
        green_nxt = fill_cfg.green;
        blue_nxt  = fill_cfg.blue;
        alpha_nxt = fill_cfg.alpha;
      end
      MODE_ELLIPSE: begin
        if (ell_hit) begin
          red_nxt   = fill_cfg.red;
          green_nxt = fill_cfg.green;
          blue_nxt  = fill_cfg.blue;
          alpha_nxt = fill_cfg.alpha;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (vld_r[STG-1]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      alpha_r <= alpha_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;
  assign out_alpha = alpha_r;

  // every transfer yields a strobe after the input, pipeline and output registers
  `PTEX_ASSERT_IMP(a_lat_fwd, accept, ##ACC_LAT out_valid_r, "result missing after transfer")
  // every strobe traces back to a transfer
  `PTEX_ASSERT_IMP(a_lat_back, out_valid_r, $past(accept, ACC_LAT), "result without transfer")

endmodule

`default_nettype wire
